// ===== rtl/assert_macros.svh =====
// assertion helpers for the engine core rtl, clocked on clk, off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kcc_pkg.sv =====
package kcc_pkg;

    localparam int CH_W            = 16;   // 8.8 channel
    localparam int SUM_W           = 28;
    localparam int COUNT_W         = 21;
    localparam int DIST_W          = 34;
    localparam int DIV_STEPS       = 16;
    localparam int MAX_CLUSTERS_DEF = 8;
    localparam int MAX_PASS_PIXELS = 1048576;
    localparam int COUNT_MAX       = 2097151;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (MAX_PASS_PIXELS < COUNT_MAX) ? COUNT_W'(MAX_PASS_PIXELS) : COUNT_W'(COUNT_MAX);

    localparam logic [1:0] KIND_SEED = 2'd0;
    localparam logic [1:0] KIND_ACC  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_MAP  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_SEARCH,
        ST_ACC_RD,
        ST_ACC_UPD,
        ST_END_RD,
        ST_END_CHK,
        ST_END_DIV,
        ST_END_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } centroid_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum_red;
        logic [SUM_W-1:0]   sum_green;
        logic [SUM_W-1:0]   sum_blue;
    } acc_entry_t;

    typedef struct packed {
        logic cen_rd;
        logic cen_wr;
        logic acc_rd;
        logic acc_wr;
        logic acc_clear;
    } store_ctl_t;

    typedef struct packed {
        logic valid;
        logic last;
    } search_tag_t;

endpackage

// ===== rtl/kcc_store.sv =====
module kcc_store #(
    parameter int MAX_CLUSTERS = kcc_pkg::MAX_CLUSTERS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  kcc_pkg::store_ctl_t                ctl,
    input  logic [$clog2(MAX_CLUSTERS)-1:0]    cen_addr,
    input  kcc_pkg::centroid_t                 cen_wr_data,
    output kcc_pkg::centroid_t                 cen_rd_data,
    input  logic [$clog2(MAX_CLUSTERS)-1:0]    acc_addr,
    input  kcc_pkg::acc_entry_t                acc_wr_data,
    output kcc_pkg::acc_entry_t                acc_rd_data
);
    import kcc_pkg::*;

    centroid_t  cen_mem [MAX_CLUSTERS];
    acc_entry_t acc_mem [MAX_CLUSTERS];

    logic [MAX_CLUSTERS-1:0] cen_valid_reg;
    logic [MAX_CLUSTERS-1:0] acc_valid_reg;
    centroid_t               cen_q_reg;
    acc_entry_t              acc_q_reg;
    logic                    cen_q_valid_reg;
    logic                    acc_q_valid_reg;

    // entries never written since reset (or since the last pass for sums) read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_valid_reg   <= '0;
            acc_valid_reg   <= '0;
            cen_q_valid_reg <= 1'b0;
            acc_q_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.cen_wr)
            begin
                cen_valid_reg[cen_addr] <= 1'b1;
            end
            if (ctl.acc_clear)
            begin
                acc_valid_reg <= '0;
            end
            else if (ctl.acc_wr)
            begin
                acc_valid_reg[acc_addr] <= 1'b1;
            end
            if (ctl.cen_rd)
            begin
                cen_q_valid_reg <= cen_valid_reg[cen_addr];
            end
            if (ctl.acc_rd)
            begin
                acc_q_valid_reg <= acc_valid_reg[acc_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cen_wr)
        begin
            cen_mem[cen_addr] <= cen_wr_data;
        end
        if (ctl.cen_rd)
        begin
            cen_q_reg <= cen_mem[cen_addr];
        end
        if (ctl.acc_wr)
        begin
            acc_mem[acc_addr] <= acc_wr_data;
        end
        if (ctl.acc_rd)
        begin
            acc_q_reg <= acc_mem[acc_addr];
        end
    end

    assign cen_rd_data = cen_q_valid_reg ? cen_q_reg : '0;
    assign acc_rd_data = acc_q_valid_reg ? acc_q_reg : '0;

endmodule

// ===== rtl/kcc_dist.sv =====
module kcc_dist #(
    parameter int IDX_W = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kcc_pkg::search_tag_t        in_tag,
    input  logic [IDX_W-1:0]            in_idx,
    input  kcc_pkg::centroid_t          centroid,
    input  logic [7:0]                  red,
    input  logic [7:0]                  green,
    input  logic [7:0]                  blue,
    output kcc_pkg::search_tag_t        out_tag,
    output logic [IDX_W-1:0]            out_idx,
    output logic [kcc_pkg::DIST_W-1:0]  out_dist,
    output logic [23:0]                 out_color
);
    import kcc_pkg::*;

    logic [CH_W-1:0]   px [3];
    logic [CH_W-1:0]   ch [3];
    logic [CH_W-1:0]   diff [3];

    search_tag_t       tag1_reg, tag2_reg, tag3_reg;
    logic [IDX_W-1:0]  idx1_reg, idx2_reg, idx3_reg;
    logic [23:0]       color1_reg, color2_reg, color3_reg;
    logic [CH_W-1:0]   diff_reg [3];
    logic [2*CH_W-1:0] sq_reg [3];
    logic [DIST_W-1:0] dist_reg;

    always_comb
    begin
        px[0] = {red, 8'h00};
        px[1] = {green, 8'h00};
        px[2] = {blue, 8'h00};
        ch[0] = centroid.red;
        ch[1] = centroid.green;
        ch[2] = centroid.blue;
        for (int c = 0; c < 3; c++)
        begin
            diff[c] = (ch[c] > px[c]) ? (ch[c] - px[c]) : (px[c] - ch[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // abs diff, square, sum: one register after each
    always_ff @(posedge clk)
    begin
        idx1_reg   <= in_idx;
        color1_reg <= {centroid.red[15:8], centroid.green[15:8], centroid.blue[15:8]};
        for (int c = 0; c < 3; c++)
        begin
            diff_reg[c] <= diff[c];
            sq_reg[c]   <= diff_reg[c] * diff_reg[c];
        end
        idx2_reg   <= idx1_reg;
        color2_reg <= color1_reg;
        dist_reg   <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        idx3_reg   <= idx2_reg;
        color3_reg <= color2_reg;
    end

    assign out_tag   = tag3_reg;
    assign out_idx   = idx3_reg;
    assign out_dist  = dist_reg;
    assign out_color = color3_reg;

endmodule

// ===== rtl/kcc_div.sv =====
module kcc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  kcc_pkg::acc_entry_t  entry,
    output logic                 done,
    output kcc_pkg::centroid_t   quotient
);
    import kcc_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic [SUM_W-1:0]    sum_in [3];
    logic [COUNT_W-1:0]  rem_reg [3];
    logic [CH_W-1:0]     sh_reg [3];
    logic [COUNT_W-1:0]  divisor_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [COUNT_W:0]    trial [3];
    logic [COUNT_W-1:0]  rem_n [3];
    logic                qbit [3];

    always_comb
    begin
        sum_in[0] = entry.sum_red;
        sum_in[1] = entry.sum_green;
        sum_in[2] = entry.sum_blue;
        for (int c = 0; c < 3; c++)
        begin
            trial[c] = {rem_reg[c], sh_reg[c][CH_W-1]};
            qbit[c]  = (trial[c] >= {1'b0, divisor_reg});
            rem_n[c] = qbit[c] ? COUNT_W'(trial[c] - {1'b0, divisor_reg})
                               : trial[c][COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // mean never exceeds 255.0, so the upper sum bits start below the divisor
    // and only sixteen quotient bits remain; quotient bits shift in as dividend bits leave
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= entry.count;
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[c] <= COUNT_W'(sum_in[c][SUM_W-1:8]);
                sh_reg[c]  <= {sum_in[c][7:0], 8'h00};
            end
        end
        else if (busy_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[c] <= rem_n[c];
                sh_reg[c]  <= {sh_reg[c][CH_W-2:0], qbit[c]};
            end
        end
    end

    assign done           = done_reg;
    assign quotient.red   = sh_reg[0];
    assign quotient.green = sh_reg[1];
    assign quotient.blue  = sh_reg[2];

endmodule

// ===== rtl/kmeans_color_cluster_engine_core.sv =====
// k-means color clustering engine: up to MAX_CLUSTERS centroids in 8.8 fixed point,
// each with channel sums and a member count, all held in single-port memories.
// an input beat carries kind in tuser (seed, accumulate, end pass, map) and one
// result beat comes back for every input beat. the search of map and accumulate
// reads one centroid per cycle, for each of the active clusters, through the
// distance pipe, and accumulate then reads and writes back the winner's sums.
// end pass walks the active clusters, running a sixteen-step shared divider for
// the three channel means of each one with members and skipping empty ones.
// memories need no clearing pass after reset. a new beat is taken while the
// previous result still waits on the output side.
module kmeans_color_cluster_engine_core #(
    parameter int MAX_CLUSTERS = kcc_pkg::MAX_CLUSTERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,      // num_clusters
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,     // red, green, blue, cluster_slot, zero pad
    input  logic [1:0]  s_axis_tuser,     // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata      // cluster_index, out_red, out_green, out_blue,
                                          // empty_clusters, status
);
    import kcc_pkg::*;

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_CLUSTERS);
    localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

    state_t             state_reg, state_next;
    logic [3:0]         num_clusters_reg;
    logic               overflow_flag_reg;
    logic [1:0]         kind_reg;
    logic [7:0]         red_reg, green_reg, blue_reg;
    logic [2:0]         slot_reg;
    logic [IDX_W-1:0]   issue_k_reg;
    logic               issuing_reg;
    search_tag_t        tag_q_reg;
    logic [IDX_W-1:0]   tag_idx_q_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [23:0]        best_color_reg;
    logic [IDX_W-1:0]   end_k_reg;
    logic [CNT_W-1:0]   empty_reg;
    logic [2:0]         res_idx_reg;
    logic [23:0]        res_color_reg;
    logic [3:0]         res_empty_reg;
    logic               res_status_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;

    logic [4:0]         num5;
    logic [4:0]         n5;
    logic [CNT_W-1:0]   n_act;
    logic               in_accept;
    logic               out_load;
    logic               seed_ok;
    logic               issue_last;
    logic               end_last;
    store_ctl_t         ctl;
    logic [IDX_W-1:0]   cen_addr;
    logic [IDX_W-1:0]   acc_addr;
    centroid_t          cen_wr_data;
    centroid_t          cen_rd_data;
    acc_entry_t         acc_wr_data;
    acc_entry_t         acc_rd_data;
    logic               div_start;
    logic               div_done;
    centroid_t          div_q;
    search_tag_t        dist_tag;
    logic [IDX_W-1:0]   dist_idx;
    logic [DIST_W-1:0]  dist_val;
    logic [23:0]        dist_color;
    logic               take_new;
    logic [IDX_W-1:0]   fin_idx;
    logic [23:0]        fin_color;
    logic [SUM_W:0]     add_r, add_g, add_b;
    logic               acc_ovf;

    // active count: zero acts as one, large values clamp to the memory depth
    always_comb
    begin
        num5 = {1'b0, num_clusters_reg};
        if (num5 == 5'd0)
        begin
            n5 = 5'd1;
        end
        else if (num5 > 5'(MAX_CLUSTERS))
        begin
            n5 = 5'(MAX_CLUSTERS);
        end
        else
        begin
            n5 = num5;
        end
        n_act = CNT_W'(n5);
    end

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign seed_ok       = ({2'b00, slot_reg} < n5);
    assign issue_last    = (CNT_W'(issue_k_reg) == n_act - CNT_W'(1));
    assign end_last      = (CNT_W'(end_k_reg) == n_act - CNT_W'(1));

    always_comb
    begin
        take_new  = (dist_idx == '0) || (dist_val < best_dist_reg);
        fin_idx   = take_new ? dist_idx : best_idx_reg;
        fin_color = take_new ? dist_color : best_color_reg;
    end

    // overflow: sum past 28 bits or count at its limit leaves the entry untouched
    always_comb
    begin
        add_r   = (SUM_W+1)'(acc_rd_data.sum_red) + (SUM_W+1)'(red_reg);
        add_g   = (SUM_W+1)'(acc_rd_data.sum_green) + (SUM_W+1)'(green_reg);
        add_b   = (SUM_W+1)'(acc_rd_data.sum_blue) + (SUM_W+1)'(blue_reg);
        acc_ovf = add_r[SUM_W] || add_g[SUM_W] || add_b[SUM_W]
               || (acc_rd_data.count >= COUNT_LIMIT);
        acc_wr_data.count     = acc_rd_data.count + COUNT_W'(1);
        acc_wr_data.sum_red   = add_r[SUM_W-1:0];
        acc_wr_data.sum_green = add_g[SUM_W-1:0];
        acc_wr_data.sum_blue  = add_b[SUM_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (s_axis_tuser)
                        KIND_SEED: state_next = ST_SEED;
                        KIND_END:  state_next = ST_END_RD;
                        default:   state_next = ST_SEARCH;
                    endcase
                end
            end
            ST_SEED:    state_next = ST_DONE;
            ST_SEARCH:
            begin
                if (dist_tag.valid && dist_tag.last)
                begin
                    state_next = (kind_reg == KIND_ACC) ? ST_ACC_RD : ST_DONE;
                end
            end
            ST_ACC_RD:  state_next = ST_ACC_UPD;
            ST_ACC_UPD: state_next = ST_DONE;
            ST_END_RD:  state_next = ST_END_CHK;
            ST_END_CHK:
            begin
                if (acc_rd_data.count != '0)
                begin
                    state_next = ST_END_DIV;
                end
                else
                begin
                    state_next = end_last ? ST_END_FIN : ST_END_RD;
                end
            end
            ST_END_DIV:
            begin
                if (div_done)
                begin
                    state_next = end_last ? ST_END_FIN : ST_END_RD;
                end
            end
            ST_END_FIN: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb
    begin
        ctl         = '0;
        cen_addr    = issue_k_reg;
        acc_addr    = best_idx_reg;
        cen_wr_data = '0;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_SEED:
            begin
                ctl.cen_wr  = seed_ok;
                cen_addr    = IDX_W'(slot_reg);
                cen_wr_data = '{red: {red_reg, 8'h00}, green: {green_reg, 8'h00},
                                blue: {blue_reg, 8'h00}};
            end
            ST_SEARCH:
            begin
                ctl.cen_rd = issuing_reg;
            end
            ST_ACC_RD:
            begin
                ctl.acc_rd = 1'b1;
            end
            ST_ACC_UPD:
            begin
                ctl.acc_wr = !acc_ovf;
            end
            ST_END_RD:
            begin
                ctl.acc_rd = 1'b1;
                acc_addr   = end_k_reg;
            end
            ST_END_CHK:
            begin
                div_start = (acc_rd_data.count != '0);
            end
            ST_END_DIV:
            begin
                ctl.cen_wr  = div_done;
                cen_addr    = end_k_reg;
                cen_wr_data = div_q;
            end
            ST_END_FIN:
            begin
                ctl.acc_clear = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            num_clusters_reg  <= 4'd2;
            overflow_flag_reg <= 1'b0;
            issue_k_reg       <= '0;
            issuing_reg       <= 1'b0;
            tag_q_reg         <= '0;
            end_k_reg         <= '0;
            empty_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                num_clusters_reg <= cfg_wr_data;
            end
            if (in_accept)
            begin
                issue_k_reg <= '0;
                issuing_reg <= (s_axis_tuser == KIND_ACC) || (s_axis_tuser == KIND_MAP);
                end_k_reg   <= '0;
                empty_reg   <= '0;
            end
            else if (state_reg == ST_SEARCH && issuing_reg)
            begin
                if (issue_last)
                begin
                    issuing_reg <= 1'b0;
                end
                else
                begin
                    issue_k_reg <= issue_k_reg + IDX_W'(1);
                end
            end
            // tag lines up with the registered centroid read
            tag_q_reg.valid <= (state_reg == ST_SEARCH) && issuing_reg;
            tag_q_reg.last  <= issue_last;
            if (state_reg == ST_ACC_UPD && acc_ovf)
            begin
                overflow_flag_reg <= 1'b1;
            end
            if (state_reg == ST_END_FIN)
            begin
                overflow_flag_reg <= 1'b0;
            end
            if (state_reg == ST_END_CHK && acc_rd_data.count == '0)
            begin
                empty_reg <= empty_reg + CNT_W'(1);
                end_k_reg <= end_k_reg + IDX_W'(!end_last);
            end
            if (state_reg == ST_END_DIV && div_done)
            begin
                end_k_reg <= end_k_reg + IDX_W'(!end_last);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_idx_q_reg <= issue_k_reg;
        if (in_accept)
        begin
            kind_reg  <= s_axis_tuser;
            red_reg   <= s_axis_tdata[7:0];
            green_reg <= s_axis_tdata[15:8];
            blue_reg  <= s_axis_tdata[23:16];
            slot_reg  <= s_axis_tdata[26:24];
        end
        if (state_reg == ST_SEARCH && dist_tag.valid)
        begin
            best_idx_reg   <= fin_idx;
            best_dist_reg  <= take_new ? dist_val : best_dist_reg;
            best_color_reg <= fin_color;
            res_idx_reg    <= 3'(fin_idx);
            res_color_reg  <= fin_color;
            res_empty_reg  <= 4'd0;
            res_status_reg <= overflow_flag_reg;
        end
        if (state_reg == ST_SEED)
        begin
            res_idx_reg    <= seed_ok ? slot_reg : 3'd0;
            res_color_reg  <= seed_ok ? {red_reg, green_reg, blue_reg} : 24'd0;
            res_empty_reg  <= 4'd0;
            res_status_reg <= overflow_flag_reg;
        end
        if (state_reg == ST_ACC_UPD)
        begin
            res_status_reg <= overflow_flag_reg || acc_ovf;
        end
        if (state_reg == ST_END_FIN)
        begin
            res_idx_reg    <= 3'd0;
            res_color_reg  <= 24'd0;
            res_empty_reg  <= 4'(empty_reg);
            res_status_reg <= overflow_flag_reg;
        end
        if (out_load)
        begin
            out_data_reg <= {res_status_reg, res_empty_reg, res_color_reg[7:0],
                             res_color_reg[15:8], res_color_reg[23:16], res_idx_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    kcc_store #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cen_addr    (cen_addr),
        .cen_wr_data (cen_wr_data),
        .cen_rd_data (cen_rd_data),
        .acc_addr    (acc_addr),
        .acc_wr_data (acc_wr_data),
        .acc_rd_data (acc_rd_data)
    );

    kcc_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (tag_q_reg),
        .in_idx    (tag_idx_q_reg),
        .centroid  (cen_rd_data),
        .red       (red_reg),
        .green     (green_reg),
        .blue      (blue_reg),
        .out_tag   (dist_tag),
        .out_idx   (dist_idx),
        .out_dist  (dist_val),
        .out_color (dist_color)
    );

    kcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .entry    (acc_rd_data),
        .done     (div_done),
        .quotient (div_q)
    );

    `KCC_ASSERT_NOW(a_search_in_search, dist_tag.valid, state_reg == ST_SEARCH,
        "distance result outside a search")
    `KCC_ASSERT_NOW(a_best_active,
        (state_reg == ST_DONE) && ((kind_reg == KIND_ACC) || (kind_reg == KIND_MAP)),
        CNT_W'(best_idx_reg) < n_act, "nearest centroid not active")
    `KCC_ASSERT_NOW(a_flag_cleared, (state_reg == ST_DONE) && (kind_reg == KIND_END),
        !overflow_flag_reg, "overflow flag survives end of pass")
    `KCC_ASSERT_NEXT(a_div_done, (state_reg == ST_END_DIV) && div_done,
        (state_reg == ST_END_RD) || (state_reg == ST_END_FIN), "divider done lost")

endmodule

// ===== tb/kcc_checker.sv =====
module kcc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,     // red, green, blue, cluster_slot, zero pad
    input  logic [1:0]  s_axis_tuser,     // kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,     // cluster_index, out_red, out_green, out_blue,
                                          // empty_clusters, status
    output int          fail_count,
    output int          results_pending,
    output int          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import kcc_pkg::*;

    localparam logic [SUM_W-1:0] SUM_FULL = '1;

    typedef struct packed {
        logic [2:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] empty;
        logic       status;
    } cluster_result_t;

    logic [3:0]         cluster_setting;
    centroid_t          centroids [MAX_CLUSTERS_DEF];
    logic [SUM_W-1:0]   red_sum   [MAX_CLUSTERS_DEF];
    logic [SUM_W-1:0]   green_sum [MAX_CLUSTERS_DEF];
    logic [SUM_W-1:0]   blue_sum  [MAX_CLUSTERS_DEF];
    logic [COUNT_W-1:0] members   [MAX_CLUSTERS_DEF];
    logic               pass_overflow;
    cluster_result_t    expected_colors [$];

    function automatic int live_count();
        int n;
        n = cluster_setting;
        if (n < 1) n = 1;
        if (n > MAX_CLUSTERS_DEF) n = MAX_CLUSTERS_DEF;
        return n;
    endfunction

    // squared channel distance of 8.8 channels, so in 16.16 units
    function automatic longint unsigned channel_gap(logic [CH_W-1:0] c, logic [7:0] p);
        longint unsigned a;
        longint unsigned b;
        longint unsigned d;
        a = c;
        b = {p, 8'h00};
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    function automatic int closest_centroid(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int best;
        longint unsigned best_d;
        longint unsigned d;
        best = 0;
        best_d = 0;
        for (int k = 0; k < live_count(); k++) begin
            d = channel_gap(centroids[k].red, r) + channel_gap(centroids[k].green, g)
              + channel_gap(centroids[k].blue, b);
            // strict less-than keeps the lowest index on a tie
            if (k == 0 || d < best_d) begin
                best = k;
                best_d = d;
            end
        end
        return best;
    endfunction

    function automatic cluster_result_t centroid_color(int k);
        cluster_result_t res;
        res = '0;
        res.index = k[2:0];
        res.red   = centroids[k].red[15:8];
        res.green = centroids[k].green[15:8];
        res.blue  = centroids[k].blue[15:8];
        return res;
    endfunction

    function automatic cluster_result_t predict_cluster_beat(logic [1:0] kind, logic [7:0] r,
                                                             logic [7:0] g, logic [7:0] b,
                                                             logic [2:0] slot);
        cluster_result_t res;
        int k;
        int n;
        int empties;
        logic [35:0] mean_r;
        logic [35:0] mean_g;
        logic [35:0] mean_b;
        res = '0;
        n = live_count();
        empties = 0;
        case (kind)
            KIND_SEED: begin
                if (int'(slot) < n) begin
                    centroids[slot].red   = {r, 8'h00};
                    centroids[slot].green = {g, 8'h00};
                    centroids[slot].blue  = {b, 8'h00};
                    res = centroid_color(slot);
                end
                res.status = pass_overflow;
            end
            KIND_ACC: begin
                k = closest_centroid(r, g, b);
                if ((29'(red_sum[k]) + r) > 29'(SUM_FULL)
                    || (29'(green_sum[k]) + g) > 29'(SUM_FULL)
                    || (29'(blue_sum[k]) + b) > 29'(SUM_FULL)
                    || members[k] >= COUNT_LIMIT) begin
                    pass_overflow = 1'b1;
                end else begin
                    red_sum[k]   += r;
                    green_sum[k] += g;
                    blue_sum[k]  += b;
                    members[k]   += 1;
                end
                res = centroid_color(k);
                res.status = pass_overflow;
            end
            KIND_END: begin
                for (k = 0; k < n; k++) begin
                    if (members[k] == 0) begin
                        empties++;
                    end else begin
                        mean_r = {red_sum[k], 8'h00} / members[k];
                        mean_g = {green_sum[k], 8'h00} / members[k];
                        mean_b = {blue_sum[k], 8'h00} / members[k];
                        centroids[k].red   = mean_r[15:0];
                        centroids[k].green = mean_g[15:0];
                        centroids[k].blue  = mean_b[15:0];
                    end
                end
                res.empty  = empties[3:0];
                res.status = pass_overflow;
                for (k = 0; k < MAX_CLUSTERS_DEF; k++) begin
                    red_sum[k]   = '0;
                    green_sum[k] = '0;
                    blue_sum[k]  = '0;
                    members[k]   = '0;
                end
                pass_overflow = 1'b0;
            end
            KIND_MAP: begin
                res = centroid_color(closest_centroid(r, g, b));
                res.status = pass_overflow;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] cluster result mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic compare_beat(cluster_result_t want, logic [31:0] beat);
        if (beat[2:0] !== want.index)
            report_mismatch($sformatf("cluster_index expected %0d got %0d", want.index,
                                      beat[2:0]));
        if (beat[10:3] !== want.red)
            report_mismatch($sformatf("out_red expected %0d got %0d", want.red, beat[10:3]));
        if (beat[18:11] !== want.green)
            report_mismatch($sformatf("out_green expected %0d got %0d", want.green,
                                      beat[18:11]));
        if (beat[26:19] !== want.blue)
            report_mismatch($sformatf("out_blue expected %0d got %0d", want.blue,
                                      beat[26:19]));
        if (beat[30:27] !== want.empty)
            report_mismatch($sformatf("empty_clusters expected %0d got %0d", want.empty,
                                      beat[30:27]));
        if (beat[31] !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d", want.status, beat[31]));
    endtask

    always @(posedge clk or negedge rst_n) begin
        cluster_result_t want;
        if (!rst_n) begin
            cluster_setting = 4'd2;
            for (int k = 0; k < MAX_CLUSTERS_DEF; k++) begin
                centroids[k] = '0;
                red_sum[k]   = '0;
                green_sum[k] = '0;
                blue_sum[k]  = '0;
                members[k]   = '0;
            end
            pass_overflow = 1'b0;
            expected_colors.delete();
            results_pending <= 0;
        end else begin
            if (cfg_wr_en)
                cluster_setting = cfg_wr_data;
            // retire the output beat first so a beat never meets its own prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch($sformatf("result beat 0x%08h with nothing expected",
                                              m_axis_tdata));
                end else begin
                    want = expected_colors.pop_front();
                    compare_beat(want, m_axis_tdata);
                    results_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_colors.insert(expected_colors.size(), predict_cluster_beat(
                    s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                    s_axis_tdata[23:16], s_axis_tdata[26:24]));
            results_pending <= expected_colors.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import kcc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = 4'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;       // red, green, blue, cluster_slot, zero pad
    logic [1:0]  s_axis_tuser = KIND_SEED; // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // cluster_index, out_red, out_green, out_blue,
                                          // empty_clusters, status

    int          fail_count;
    int          results_pending;
    int          results_checked;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          live_clusters = 2;
    int          beats_sent = 0;
    int          setting_writes = 0;
    int          sent_by_kind [4] = '{0, 0, 0, 0};
    logic [23:0] seed_color [8] = '{default: '0};

    kmeans_color_cluster_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    kcc_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, results_pending);
            $display("** kmeans_color_cluster_engine_core: FAILED **");
            $finish;
        end
    end

    function automatic logic [7:0] any_level();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // small jitter around a seeded channel so pixels land in a real cluster
    function automatic logic [7:0] near_level(logic [7:0] v);
        int t;
        t = int'(v) + int'($urandom_range(12)) - 6;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return t[7:0];
    endfunction

    task automatic push_pixel(input logic [1:0] kind, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b,
                              input logic [2:0] slot);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'b0, slot, b, g, r};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        beats_sent++;
        sent_by_kind[kind]++;
        if (kind == KIND_SEED && int'(slot) < live_clusters)
            seed_color[slot] = {r, g, b};
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_clusters(input logic [3:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        live_clusters = (v == 0) ? 1 : ((v > 8) ? 8 : int'(v));
        setting_writes++;
    endtask

    task automatic random_pixel(input logic [1:0] kind, input logic [2:0] slot);
        push_pixel(kind, any_level(), any_level(), any_level(), slot);
    endtask

    // one well-formed clustering pass: optional seeding, accumulate, optional maps, update, map
    task automatic run_pass(input bit reseed);
        int k;
        logic [23:0] c;
        if (reseed)
            for (k = 0; k < live_clusters; k++)
                random_pixel(KIND_SEED, k[2:0]);
        repeat ($urandom_range(3, 16))
        begin
            if ($urandom_range(9) < 7)
            begin
                c = seed_color[$urandom_range(live_clusters - 1)];
                push_pixel(KIND_ACC, near_level(c[23:16]), near_level(c[15:8]),
                           near_level(c[7:0]), 3'($urandom_range(7)));
            end
            else
            begin
                random_pixel(KIND_ACC, 3'($urandom_range(7)));
            end
        end
        repeat ($urandom_range(0, 2)) random_pixel(KIND_MAP, 3'($urandom_range(7)));
        random_pixel(KIND_END, 3'($urandom_range(7)));
        repeat ($urandom_range(1, 2)) random_pixel(KIND_MAP, 3'($urandom_range(7)));
    endtask

    function automatic logic [3:0] pick_setting();
        case ($urandom_range(5))
            0: return 4'd1;
            1: return 4'd8;
            2: return 4'd0;
            3: return 4'd15;
            default: return 4'($urandom_range(2, 7));
        endcase
    endfunction

    initial
    begin
        int phase_start;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setting of two clusters, all centroids at zero
        push_pixel(KIND_MAP, 8'd0, 8'd0, 8'd0, 3'd5);          // tie on all zero, index 0
        push_pixel(KIND_SEED, 8'd0, 8'd0, 8'd0, 3'd0);
        push_pixel(KIND_SEED, 8'd255, 8'd255, 8'd255, 3'd1);
        push_pixel(KIND_SEED, 8'd12, 8'd34, 8'd56, 3'd7);      // inactive slot, ignored
        push_pixel(KIND_ACC, 8'd0, 8'd0, 8'd0, 3'd0);
        push_pixel(KIND_ACC, 8'd255, 8'd255, 8'd255, 3'd7);
        push_pixel(KIND_ACC, 8'd128, 8'd128, 8'd128, 3'd2);
        push_pixel(KIND_ACC, 8'd127, 8'd127, 8'd127, 3'd3);
        push_pixel(KIND_END, 8'd255, 8'd0, 8'd255, 3'd7);
        push_pixel(KIND_MAP, 8'd200, 8'd10, 8'd90, 3'd0);
        drain();                                              // hold off until all results are back
        push_pixel(KIND_ACC, 8'd255, 8'd255, 8'd255, 3'd0);
        push_pixel(KIND_END, 8'd0, 8'd0, 8'd0, 3'd0);         // one cluster empty
        set_clusters(4'd1);
        push_pixel(KIND_SEED, 8'd9, 8'd9, 8'd9, 3'd1);         // slot beyond active count
        push_pixel(KIND_END, 8'd0, 8'd0, 8'd0, 3'd0);
        set_clusters(4'd8);
        push_pixel(KIND_SEED, 8'd100, 8'd150, 8'd200, 3'd7);
        push_pixel(KIND_SEED, 8'd100, 8'd150, 8'd200, 3'd3);   // equal centroids, lower wins
        push_pixel(KIND_MAP, 8'd100, 8'd150, 8'd200, 3'd0);
        push_pixel(KIND_END, 8'd0, 8'd0, 8'd0, 3'd0);         // every active cluster empty
        set_clusters(4'd0);                                    // behaves as one cluster
        push_pixel(KIND_MAP, 8'd255, 8'd255, 8'd255, 3'd0);
        set_clusters(4'd15);                                   // clamps to eight
        push_pixel(KIND_SEED, 8'd1, 8'd2, 8'd3, 3'd7);
        push_pixel(KIND_MAP, 8'd1, 8'd2, 8'd3, 3'd6);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 30; rx_idle_pct = 80; end
                1: begin tx_idle_pct = 80; rx_idle_pct = 30; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_ITEMS)
            begin
                set_clusters(pick_setting());
                run_pass(1'b1);
                if ($urandom_range(1))
                    run_pass(1'b0);
                // noise: any kind, any slot, outside a proper pass
                repeat ($urandom_range(0, 4))
                    random_pixel(2'($urandom_range(3)), 3'($urandom_range(7)));
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("sent %0d beats: %0d seed, %0d accumulate, %0d end pass, %0d map",
                 beats_sent, sent_by_kind[KIND_SEED], sent_by_kind[KIND_ACC],
                 sent_by_kind[KIND_END], sent_by_kind[KIND_MAP]);
        $display("%0d cluster count writes, %0d results compared, %0d mismatches",
                 setting_writes, results_checked, fail_count);
        if (fail_count == 0)
            $display("** kmeans_color_cluster_engine_core: PASSED **");
        else
            $display("** kmeans_color_cluster_engine_core: FAILED **");
        $finish;
    end

endmodule

// ===== kmeans_color_cluster_engine_core.f =====
+incdir+rtl
rtl/kcc_pkg.sv
rtl/kcc_store.sv
rtl/kcc_dist.sv
rtl/kcc_div.sv
rtl/kmeans_color_cluster_engine_core.sv
tb/kcc_checker.sv
tb/tb_top.sv
